[sv/bbgs_pkg.sv]
// ----------------------------------------------------------------------------
// bbgs_pkg
// Types, codes and sizes shared by the generation step unit and its port
// checker.
// ----------------------------------------------------------------------------
package bbgs_pkg;

   localparam int CNT_W        = 7;
   localparam int IDX_W        = 6;
   localparam int CELL_W       = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   // Cell states
   localparam logic [CELL_W-1:0] CELL_DEAD   = 2'd0;
   localparam logic [CELL_W-1:0] CELL_LIVE   = 2'd1;
   localparam logic [CELL_W-1:0] CELL_DYING  = 2'd2;
   localparam logic [CELL_W-1:0] CELL_UNUSED = 2'd3;

   // Neighbour count that turns a dead cell live
   localparam logic [3:0] BIRTH_COUNT = 4'd2;

   // Request operations
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  row_index;
      logic [IDX_W-1:0]  col_index;
      logic [CELL_W-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] read_value;
      logic              generation_done;
      logic              index_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_ADV_ROW,
      ST_ADV_CUR,
      ST_ADV_DN,
      ST_ADV_UP,
      ST_ADV_CELL,
      ST_ADV_WR,
      ST_RESP
   } state_type;

endpackage

[sv/bbgs_ram.sv]
// ----------------------------------------------------------------------------
// bbgs_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module bbgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/brians_brain_generation_step_unit.sv]
// ----------------------------------------------------------------------------
// brians_brain_generation_step_unit
// Three-state cellular automaton on a wrapped grid, one generation per
// advance request, with single-cell write and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ valid/ready channel and each produces exactly
//   one result on the rsp_ valid/ready channel. Row and column counts are set
//   through the csr_ write port while the unit is idle.
//   The grid lives in a row-wide memory, one row of cells per word. A write
//   request is a read-modify-write of its row; a read request returns one
//   cell. An advance reads the current row and its neighbours into row
//   registers, then one shared neighbour-count unit steps across the
//   columns, one cell per cycle, and the new row is written back. Each row
//   goes through the row read, the current row, the row below, the row
//   above (first row only), the column pass and the write back. Only one
//   request is worked on at a time; req_ready is high only when the unit
//   is idle.
//   After reset the memory is cleared one row per cycle, and no request is
//   taken meanwhile.
//   Results sit in an output register; a new request may be accepted while a
//   result waits, and the following result is held back until it is taken.
// ----------------------------------------------------------------------------
module brians_brain_generation_step_unit #(
   parameter int MAX_ROWS = bbgs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bbgs_pkg::DEF_MAX_COLS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bbgs_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bbgs_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [bbgs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bbgs_pkg::CNT_W-1:0]            csr_wr_data
);

   import bbgs_pkg::*;

   localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = CELL_W * MAX_COLS;

   typedef logic [MAX_COLS-1:0][CELL_W-1:0] row_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [CNT_W-1:0]  col_count_ff, col_count_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [RA-1:0]     clr_ff, clr_in;
   row_type           up_ff, up_in;
   row_type           cur_ff, cur_in;
   row_type           dn_ff, dn_in;
   row_type           old0_ff, old0_in;
   row_type           nxt_ff, nxt_in;

   logic              ram_we;
   logic [RA-1:0]     ram_waddr;
   logic [ROW_W-1:0]  ram_wdata;
   logic              ram_re;
   logic [RA-1:0]     ram_raddr;
   logic [ROW_W-1:0]  ram_rdata;
   row_type           rd_row;
   row_type           row_mod;

   logic [CNT_W-1:0]  rows_eff, cols_eff;
   logic [CNT_W-1:0]  rows_last, cols_last;
   logic              bad_index;
   logic              last_r, last_c;
   logic [CA-1:0]     col_sel, cc, lf, rt;
   logic [3:0]        live_n;
   logic [CELL_W-1:0] new_cell;

   function automatic logic [3:0] live_bit(input logic [CELL_W-1:0] v);
      return {3'b000, (v == CELL_LIVE)};
   endfunction

   bbgs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_ROWS),
      .AW    (RA)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_row = ram_rdata;

   // Sizes outside their range are clamped to the nearest legal value.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = CNT_W'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows_eff = CNT_W'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(col_count_ff) > MAX_COLS) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = col_count_ff;
      end
   end

   assign rows_last = rows_eff - 1'b1;
   assign cols_last = cols_eff - 1'b1;
   assign bad_index = (CNT_W'(req_data.row_index) >= rows_eff) ||
                      (CNT_W'(req_data.col_index) >= cols_eff);
   assign last_r    = (r_ff == rows_last);
   assign last_c    = (c_ff == cols_last);
   assign col_sel   = CA'(req_ff.col_index);

   // Shared neighbour-count unit: one cell of the row per cycle.
   assign cc = CA'(c_ff);
   assign lf = (c_ff == '0) ? CA'(cols_last) : CA'(c_ff - 1'b1);
   assign rt = last_c ? '0 : CA'(c_ff + 1'b1);

   assign live_n = live_bit(up_ff[lf]) + live_bit(up_ff[cc]) + live_bit(up_ff[rt])
                 + live_bit(cur_ff[lf]) + live_bit(cur_ff[rt])
                 + live_bit(dn_ff[lf]) + live_bit(dn_ff[cc]) + live_bit(dn_ff[rt]);

   always_comb begin
      if (cur_ff[cc] == CELL_LIVE) begin
         new_cell = CELL_DYING;
      end else if (cur_ff[cc] == CELL_DYING) begin
         new_cell = CELL_DEAD;
      end else begin
         new_cell = (live_n == BIRTH_COUNT) ? CELL_LIVE : CELL_DEAD;
      end
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wr_data;
            CSR_COL_COUNT: col_count_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      clr_in       = clr_ff;
      up_in        = up_ff;
      cur_in       = cur_ff;
      dn_in        = dn_ff;
      old0_in      = old0_ff;
      nxt_in       = nxt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      row_mod      = rd_row;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      req_ready    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == RA'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               case (req_data.op)
                  OP_WRITE, OP_READ: begin
                     if (bad_index) begin
                        res_in.index_error = 1'b1;
                        state_in = ST_RESP;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = RA'(req_data.row_index);
                        state_in  = ST_CELL;
                     end
                  end
                  OP_ADVANCE: begin
                     r_in     = '0;
                     state_in = ST_ADV_ROW;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_CELL: begin
            if (req_ff.op == OP_WRITE) begin
               row_mod[col_sel] = (req_ff.cell_value == CELL_UNUSED) ? CELL_DEAD
                                                                      : req_ff.cell_value;
               ram_we    = 1'b1;
               ram_waddr = RA'(req_ff.row_index);
               ram_wdata = row_mod;
            end else begin
               res_in.read_value = rd_row[col_sel];
            end
            state_in = ST_RESP;
         end

         // The old copy of the previous row moves up before it is overwritten.
         ST_ADV_ROW: begin
            ram_re    = 1'b1;
            ram_raddr = RA'(r_ff);
            up_in     = cur_ff;
            state_in  = ST_ADV_CUR;
         end

         ST_ADV_CUR: begin
            cur_in = rd_row;
            nxt_in = rd_row;
            if (r_ff == '0) begin
               old0_in = rd_row;
            end
            if (!last_r) begin
               ram_re    = 1'b1;
               ram_raddr = RA'(r_ff + 1'b1);
            end
            state_in = ST_ADV_DN;
         end

         // Row 0 has already been rewritten when the last row needs it, so
         // its old contents come from the saved copy.
         ST_ADV_DN: begin
            dn_in = last_r ? old0_ff : rd_row;
            c_in  = '0;
            if (r_ff == '0) begin
               ram_re    = 1'b1;
               ram_raddr = RA'(rows_last);
               state_in  = ST_ADV_UP;
            end else begin
               state_in = ST_ADV_CELL;
            end
         end

         ST_ADV_UP: begin
            up_in    = rd_row;
            state_in = ST_ADV_CELL;
         end

         ST_ADV_CELL: begin
            nxt_in[cc] = new_cell;
            c_in       = c_ff + 1'b1;
            if (last_c) begin
               state_in = ST_ADV_WR;
            end
         end

         ST_ADV_WR: begin
            ram_we    = 1'b1;
            ram_waddr = RA'(r_ff);
            ram_wdata = nxt_ff;
            if (last_r) begin
               res_in.generation_done = 1'b1;
               state_in = ST_RESP;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = ST_ADV_ROW;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= CNT_W'(MAX_ROWS);
         col_count_ff <= CNT_W'(MAX_COLS);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      up_ff       <= up_in;
      cur_ff      <= cur_in;
      dn_ff       <= dn_in;
      old0_ff     <= old0_in;
      nxt_ff      <= nxt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/bbgs_checker.sv]
// ----------------------------------------------------------------------------
// bbgs_checker
// Port-level checks on the generation step unit, bound to its top level.
// ----------------------------------------------------------------------------
module bbgs_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bbgs_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bbgs_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [bbgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbgs_pkg::CNT_W-1:0]     csr_wr_data
);

   import bbgs_pkg::*;

   // The memory clearing pass follows reset, so no request is taken at once.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken straight after reset");

   // Only one request is in progress at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("unit ready again in the cycle after accepting a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   // A result never flags both a finished generation and an index error.
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.generation_done && rsp_data.index_error))
      else $error("result flags both a generation and an index error");

   a_rsp_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.generation_done || rsp_data.index_error))
         |-> (rsp_data.read_value == CELL_DEAD))
      else $error("read value not zero on a non-read result");

endmodule

bind brians_brain_generation_step_unit bbgs_checker u_bbgs_checker (.*);
